[hdl/cstr_pkg.sv]
package cstr_pkg;

   // Character codes the scanner reacts to
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;

   // Scanner modes
   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_STRING = 3'd1,
      MODE_SLASH  = 3'd2,
      MODE_LINE   = 3'd3,
      MODE_BLOCK  = 3'd4,
      MODE_BSTAR  = 3'd5
   } mode_type;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       stream_end;
      logic       run_last;
   } rsp_type;

   // Output queue sizing: one input byte releases at most two results
   localparam int OBUF_DEPTH   = 4;
   localparam int OBUF_PTR_W   = $clog2(OBUF_DEPTH);
   localparam int OBUF_CNT_W   = $clog2(OBUF_DEPTH + 1);
   localparam int MAX_RESULTS  = 2;

   // Per-byte step outcome handed from the scanner to the output queue
   typedef struct packed {
      mode_type   next_mode;
      logic       next_prev_bs;
      logic [1:0] count;
      rsp_type    res1;
      rsp_type    res0;
   } step_type;

endpackage

[hdl/cstr_ifs.sv]
// Input byte channel
interface cstr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_last;

   modport source (output valid, output in_byte, output stream_last, input ready);
   modport sink   (input valid, input in_byte, input stream_last, output ready);
endinterface

// Result channel
interface cstr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       stream_end;
   logic       run_last;

   modport source (output valid, output out_byte, output byte_valid, output stream_end,
                   output run_last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input stream_end,
                   input run_last, output ready);
endinterface

[hdl/c_comment_stripper.sv]
// C comment stripper. Takes one source byte per cycle on req_chan while the queue has room
// and delivers the comment-free stream on rsp_chan, one result per cycle while the sink is
// ready. A byte waits in the input register, where the scanner decides its results, and
// then in a four-entry output queue. A byte releases zero, one or two results (two when a
// held slash turns out to be a plain slash), so the sustained rate is one byte per cycle as
// long as the byte stream does not release more than one result per cycle on average; the
// output drain of one result per cycle is the limit. A byte with stream_last set always
// yields at least one result, the last one flagged stream_end, and returns the scanner to
// plain-code mode for the next stream.
module c_comment_stripper
   import cstr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cstr_req_if.sink    req_chan,
   cstr_rsp_if.source  rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   mode_type   mode_ff;
   logic       prev_bs_ff;
   step_type   step;
   logic       room;
   logic       advance;
   logic       accept;

   // input register moves on when the queue can absorb two results
   assign advance          = in_valid_ff && room;
   assign req_chan.ready   = !in_valid_ff || advance;
   assign accept           = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_NORMAL;
         prev_bs_ff  <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            mode_ff    <= step.next_mode;
            prev_bs_ff <= step.next_prev_bs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_chan.in_byte;
         in_last_ff <= req_chan.stream_last;
      end
   end

   cstr_step u_step (
      .mode    (mode_ff),
      .prev_bs (prev_bs_ff),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .step    (step)
   );

   cstr_obuf u_obuf (
      .clock    (clock),
      .reset    (reset),
      .push_en  (advance),
      .step     (step),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

[hdl/cstr_step.sv]
module cstr_step
   import cstr_pkg::*;
(
   input  mode_type   mode,
   input  logic       prev_bs,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output step_type   step
);

   mode_type   nm;
   logic       npb;
   logic [1:0] n;
   rsp_type    res [MAX_RESULTS];
   logic       do_norm;
   logic       norm_pb;

   function automatic rsp_type mk_res(logic [7:0] b, logic v);
      rsp_type r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.stream_end = 1'b0;
      r.run_last   = 1'b0;
      return r;
   endfunction

   always_comb begin
      nm      = mode;
      npb     = prev_bs;
      n       = 2'd0;
      res[0]  = '0;
      res[1]  = '0;
      do_norm = 1'b0;
      norm_pb = prev_bs;

      // mode-specific handling
      case (mode)
         MODE_STRING: begin
            if (in_byte == CH_QUOTE && !prev_bs) nm = MODE_NORMAL;
            res[n[0]] = mk_res(in_byte, 1'b1);
            n = n + 2'd1;
            npb = (in_byte == CH_BSLASH);
         end
         MODE_SLASH: begin
            if (in_byte == CH_SLASH) begin
               nm = MODE_LINE;
            end else if (in_byte == CH_STAR) begin
               nm = MODE_BLOCK;
            end else begin
               // held slash was a plain slash: release it, then treat byte as code
               res[n[0]] = mk_res(CH_SLASH, 1'b1);
               n = n + 2'd1;
               do_norm = 1'b1;
               norm_pb = 1'b0;
            end
         end
         MODE_LINE: begin
            if (in_byte == CH_NL) begin
               res[n[0]] = mk_res(CH_NL, 1'b1);
               n = n + 2'd1;
               nm = MODE_NORMAL;
               npb = 1'b0;
            end
         end
         MODE_BLOCK: begin
            if (in_byte == CH_STAR) nm = MODE_BSTAR;
         end
         MODE_BSTAR: begin
            if (in_byte == CH_SLASH) begin
               nm = MODE_NORMAL;
               npb = 1'b0;
            end else if (in_byte != CH_STAR) begin
               nm = MODE_BLOCK;
            end
         end
         default: begin
            do_norm = 1'b1;
            norm_pb = prev_bs;
         end
      endcase

      // byte seen in plain code
      if (do_norm) begin
         if (in_byte == CH_QUOTE && !norm_pb) begin
            nm = MODE_STRING;
            res[n[0]] = mk_res(in_byte, 1'b1);
            n = n + 2'd1;
            npb = 1'b0;
         end else if (in_byte == CH_SLASH) begin
            nm = MODE_SLASH;
            npb = 1'b0;
         end else begin
            nm = MODE_NORMAL;
            res[n[0]] = mk_res(in_byte, 1'b1);
            n = n + 2'd1;
            npb = (in_byte == CH_BSLASH);
         end
      end

      // end of stream: flush a held slash, always show the end, then restart
      if (in_last) begin
         if (nm == MODE_SLASH) begin
            res[n[0]] = mk_res(CH_SLASH, 1'b1);
            n = n + 2'd1;
         end
         if (n == 2'd0) begin
            res[0] = mk_res(8'h00, 1'b0);
            n = 2'd1;
         end
         res[n[1]].stream_end = 1'b1;
         nm  = MODE_NORMAL;
         npb = 1'b0;
      end
      if (n != 2'd0) res[n[1]].run_last = 1'b1;

      step.next_mode    = nm;
      step.next_prev_bs = npb;
      step.count        = n;
      step.res0         = res[0];
      step.res1         = res[1];
   end

endmodule

[hdl/cstr_obuf.sv]
module cstr_obuf
   import cstr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push_en,
   input  step_type          step,
   output logic              room,
   cstr_rsp_if.source        rsp_chan
);

   rsp_type                 q_ff [OBUF_DEPTH];
   logic [OBUF_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OBUF_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OBUF_CNT_W-1:0]   count_ff, count_in;
   logic [1:0]              push_n;
   logic                    pop;

   assign push_n = push_en ? step.count : 2'd0;
   assign pop    = rsp_chan.valid && rsp_chan.ready;
   assign room   = (count_ff <= OBUF_CNT_W'(OBUF_DEPTH - MAX_RESULTS));

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + OBUF_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + OBUF_PTR_W'(pop);
      count_in  = count_ff + OBUF_CNT_W'(push_n) - OBUF_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry writes: first result at the write pointer, second one after it
   always_ff @(posedge clock) begin
      for (int i = 0; i < OBUF_DEPTH; i++) begin
         if (push_n != 2'd0 && wr_ptr_ff == OBUF_PTR_W'(i)) begin
            q_ff[i] <= step.res0;
         end
         if (push_n == 2'd2 && OBUF_PTR_W'(wr_ptr_ff + 1'b1) == OBUF_PTR_W'(i)) begin
            q_ff[i] <= step.res1;
         end
      end
   end

   // head of queue drives the result channel
   assign rsp_chan.valid      = (count_ff != '0);
   assign rsp_chan.out_byte   = q_ff[rd_ptr_ff].out_byte;
   assign rsp_chan.byte_valid = q_ff[rd_ptr_ff].byte_valid;
   assign rsp_chan.stream_end = q_ff[rd_ptr_ff].stream_end;
   assign rsp_chan.run_last   = q_ff[rd_ptr_ff].run_last;

endmodule

[hdl/cstr_checker.sv]
module cstr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_stream_end,
   input logic       rsp_run_last
);

   // a result waiting for the sink stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_byte_valid)
         && $stable(rsp_stream_end) && $stable(rsp_run_last))
      else $error("result payload changed while stalled");

   // an empty result only marks the end of a stream
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_stream_end && rsp_run_last
         && rsp_out_byte == 8'h00)
      else $error("empty result that is not a stream end");

   // stream end is always the last result of its byte
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_last)
      else $error("stream end without run end");

endmodule

bind c_comment_stripper cstr_checker u_cstr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_byte   (rsp_chan.out_byte),
   .rsp_byte_valid (rsp_chan.byte_valid),
   .rsp_stream_end (rsp_chan.stream_end),
   .rsp_run_last   (rsp_chan.run_last)
);
